### rtl/sbpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpt_pkg
// Shared types and constants of the servo bus packet transactor.
// ----------------------------------------------------------------------------
package sbpt_pkg;

   localparam int REPLY_BUFFER_DEPTH = 8;
   localparam int REPLY_IDX_W        = $clog2(REPLY_BUFFER_DEPTH);
   localparam int RX_COUNT_W         = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int TX_IDX_W = 4;

   localparam logic [7:0] HEADER_BYTE    = 8'hFF;
   localparam logic [7:0] INSTR_READ     = 8'h02;
   localparam logic [7:0] INSTR_WRITE    = 8'h03;
   localparam logic [7:0] READ_LEN_FIELD = 8'h04;
   localparam logic [RX_COUNT_W-1:0] BASE_REPLY_COUNT = 4'd6;

   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_RX_BYTE = 2'd2,
      CMD_TIMEOUT = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_HEADER      = 3'd1,
      ST_WRONG_ID    = 3'd2,
      ST_BAD_LENGTH  = 3'd3,
      ST_CHECKSUM    = 3'd4,
      ST_SERVO_ERROR = 3'd5,
      ST_TIMEOUT     = 3'd6
   } status_type;

   typedef enum logic {
      PH_IDLE = 1'b0,
      PH_RX   = 1'b1
   } phase_type;

   // one unit of work for the back end: a packet to send or a status to report
   typedef struct packed {
      logic        is_status;
      logic        is_write;
      logic        two_bytes;
      logic [7:0]  servo_id;
      logic [7:0]  reg_addr;
      logic [15:0] write_data;
      logic [7:0]  tx_checksum;
      status_type  status;
      logic [7:0]  servo_error;
      logic [15:0] read_data;
   } job_type;

endpackage
`default_nettype wire

### rtl/sbpt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpt_front
// Accepts transactions, tracks the bus phase, collects reply bytes and
// checks the status packet; queues packet and status jobs for the back end.
// ----------------------------------------------------------------------------
module sbpt_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [1:0]          cmd,
   input  wire logic [7:0]          servo_id,
   input  wire logic [7:0]          reg_addr,
   input  wire logic [15:0]         write_data,
   input  wire logic [1:0]          byte_count,
   input  wire logic [7:0]          rx_byte,
   output      logic                push,
   output      sbpt_pkg::job_type   push_job
);

   sbpt_pkg::phase_type phase_ff, phase_in;
   logic                pend_write_ff, pend_write_in;
   logic [7:0]          pend_id_ff, pend_id_in;
   logic                pend_two_ff, pend_two_in;
   logic [sbpt_pkg::RX_COUNT_W-1:0] rx_count_ff, rx_count_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          reply_ff [sbpt_pkg::REPLY_BUFFER_DEPTH];

   logic is_request, is_rx_byte, is_timeout, two_req;
   logic [sbpt_pkg::RX_COUNT_W-1:0] count_next, expected;
   logic reply_done, reply_wr;
   logic [7:0] len_field, cnt_byte, tx_sum;
   sbpt_pkg::status_type eval_status;
   logic [7:0]  eval_serr;
   logic [15:0] eval_rd;

   assign is_request = (cmd == sbpt_pkg::CMD_READ) || (cmd == sbpt_pkg::CMD_WRITE);
   assign is_rx_byte = (cmd == sbpt_pkg::CMD_RX_BYTE);
   assign is_timeout = (cmd == sbpt_pkg::CMD_TIMEOUT);
   assign two_req    = byte_count[1];   // 0 counts as 1, 3 as 2
   assign cnt_byte   = two_req ? 8'd2 : 8'd1;

   assign count_next = rx_count_ff + 1'b1;
   assign expected   = pend_write_ff ? sbpt_pkg::BASE_REPLY_COUNT
                       : sbpt_pkg::BASE_REPLY_COUNT + (pend_two_ff ? 4'd2 : 4'd1);
   assign reply_done = (count_next >= expected);
   assign reply_wr   = accept && (phase_ff == sbpt_pkg::PH_RX) && is_rx_byte
                       && (int'(rx_count_ff) < sbpt_pkg::REPLY_BUFFER_DEPTH);

   // outgoing packet checksum
   always_comb begin
      if (cmd == sbpt_pkg::CMD_WRITE) begin
         tx_sum = servo_id + (cnt_byte + 8'd3) + sbpt_pkg::INSTR_WRITE + reg_addr
                  + write_data[7:0] + (two_req ? write_data[15:8] : 8'h00);
      end else begin
         tx_sum = servo_id + sbpt_pkg::READ_LEN_FIELD + sbpt_pkg::INSTR_READ
                  + reg_addr + cnt_byte;
      end
   end

   // reply check; the incoming byte is the checksum byte
   always_comb begin
      len_field   = pend_write_ff ? 8'd2 : (pend_two_ff ? 8'd4 : 8'd3);
      eval_status = sbpt_pkg::ST_OK;
      eval_serr   = 8'h00;
      eval_rd     = 16'h0000;
      if (reply_ff[0] != sbpt_pkg::HEADER_BYTE || reply_ff[1] != sbpt_pkg::HEADER_BYTE) begin
         eval_status = sbpt_pkg::ST_HEADER;
      end else if (reply_ff[2] != pend_id_ff) begin
         eval_status = sbpt_pkg::ST_WRONG_ID;
      end else if (reply_ff[3] != len_field) begin
         eval_status = sbpt_pkg::ST_BAD_LENGTH;
      end else begin
         eval_serr = reply_ff[4];
         if (rx_byte != ~sum_ff) begin
            eval_status = sbpt_pkg::ST_CHECKSUM;
         end else if (reply_ff[4] != 8'h00) begin
            eval_status = sbpt_pkg::ST_SERVO_ERROR;
         end else if (!pend_write_ff) begin
            eval_rd = {(pend_two_ff ? reply_ff[6] : 8'h00), reply_ff[5]};
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         sbpt_pkg::PH_IDLE: begin
            if (accept && is_request) phase_in = sbpt_pkg::PH_RX;
         end
         sbpt_pkg::PH_RX: begin
            if (accept && (is_timeout || (is_rx_byte && reply_done)))
               phase_in = sbpt_pkg::PH_IDLE;
         end
         default: phase_in = sbpt_pkg::PH_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      push          = 1'b0;
      push_job      = '0;
      pend_write_in = pend_write_ff;
      pend_id_in    = pend_id_ff;
      pend_two_in   = pend_two_ff;
      rx_count_in   = rx_count_ff;
      sum_in        = sum_ff;
      case (phase_ff)
         sbpt_pkg::PH_IDLE: begin
            if (accept && is_request) begin
               push                 = 1'b1;
               push_job.is_write    = (cmd == sbpt_pkg::CMD_WRITE);
               push_job.two_bytes   = two_req;
               push_job.servo_id    = servo_id;
               push_job.reg_addr    = reg_addr;
               push_job.write_data  = write_data;
               push_job.tx_checksum = ~tx_sum;
               pend_write_in        = (cmd == sbpt_pkg::CMD_WRITE);
               pend_id_in           = servo_id;
               pend_two_in          = two_req;
               rx_count_in          = '0;
               sum_in               = 8'h00;
            end
         end
         sbpt_pkg::PH_RX: begin
            if (accept && is_timeout) begin
               push               = 1'b1;
               push_job.is_status = 1'b1;
               push_job.status    = sbpt_pkg::ST_TIMEOUT;
               rx_count_in        = '0;
            end else if (accept && is_rx_byte) begin
               if (reply_done) begin
                  push                 = 1'b1;
                  push_job.is_status   = 1'b1;
                  push_job.status      = eval_status;
                  push_job.servo_error = eval_serr;
                  push_job.read_data   = eval_rd;
                  rx_count_in          = '0;
               end else begin
                  rx_count_in = count_next;
                  if (rx_count_ff >= 4'd2) sum_in = sum_ff + rx_byte;
               end
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= sbpt_pkg::PH_IDLE;
         pend_write_ff <= 1'b0;
         pend_id_ff    <= 8'h00;
         pend_two_ff   <= 1'b0;
         rx_count_ff   <= '0;
         sum_ff        <= 8'h00;
      end else begin
         phase_ff      <= phase_in;
         pend_write_ff <= pend_write_in;
         pend_id_ff    <= pend_id_in;
         pend_two_ff   <= pend_two_in;
         rx_count_ff   <= rx_count_in;
         sum_ff        <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reply_wr) reply_ff[rx_count_ff[sbpt_pkg::REPLY_IDX_W-1:0]] <= rx_byte;
   end

endmodule
`default_nettype wire

### rtl/sbpt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpt_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module sbpt_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire sbpt_pkg::job_type   push_job,
   input  wire logic                pop,
   output      logic                full,
   output      logic                head_valid,
   output      sbpt_pkg::job_type   head_job
);

   sbpt_pkg::job_type                 queue_ff [sbpt_pkg::QUEUE_DEPTH];
   logic [sbpt_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [sbpt_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [sbpt_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == sbpt_pkg::QUEUE_CNT_W'(sbpt_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= push_job;
   end

endmodule
`default_nettype wire

### rtl/sbpt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpt_back
// Turns queued jobs into results: one packet byte per result for a request,
// a single status result otherwise. Holds the result output register.
// ----------------------------------------------------------------------------
module sbpt_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire sbpt_pkg::job_type   head_job,
   output      logic                pop,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic                rsp_is_tx_byte,
   output      logic [7:0]          rsp_tx_byte,
   output      logic                rsp_last,
   output      logic                rsp_rx_mode,
   output      logic                rsp_done_res,
   output      logic [2:0]          rsp_status,
   output      logic [7:0]          rsp_servo_error,
   output      logic [15:0]         rsp_read_data
);

   logic [sbpt_pkg::TX_IDX_W-1:0] idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        is_tx_ff, last_ff, rx_mode_ff, done_ff;
   logic [7:0]  tx_byte_ff, serr_ff;
   logic [2:0]  status_ff;
   logic [15:0] rd_ff;

   logic load, fire, is_last;
   logic [7:0] cnt_byte, cur_byte;
   logic [sbpt_pkg::TX_IDX_W-1:0] last_idx;

   assign cnt_byte = head_job.two_bytes ? 8'd2 : 8'd1;
   assign last_idx = (head_job.is_write && head_job.two_bytes) ? 4'd8 : 4'd7;
   assign is_last  = head_job.is_status || (idx_ff == last_idx);
   assign load     = !rsp_valid_ff || rsp_ready;
   assign fire     = load && head_valid;
   assign pop      = fire && is_last;

   always_comb begin
      case (idx_ff)
         4'd0, 4'd1: cur_byte = sbpt_pkg::HEADER_BYTE;
         4'd2: cur_byte = head_job.servo_id;
         4'd3: cur_byte = head_job.is_write ? cnt_byte + 8'd3 : sbpt_pkg::READ_LEN_FIELD;
         4'd4: cur_byte = head_job.is_write ? sbpt_pkg::INSTR_WRITE : sbpt_pkg::INSTR_READ;
         4'd5: cur_byte = head_job.reg_addr;
         4'd6: cur_byte = head_job.is_write ? head_job.write_data[7:0] : cnt_byte;
         4'd7: cur_byte = (head_job.is_write && head_job.two_bytes)
                          ? head_job.write_data[15:8] : head_job.tx_checksum;
         default: cur_byte = head_job.tx_checksum;
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) rsp_valid_in = head_valid;
      if (fire) idx_in = is_last ? '0 : idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         is_tx_ff   <= !head_job.is_status;
         tx_byte_ff <= head_job.is_status ? 8'h00 : cur_byte;
         last_ff    <= is_last;
         rx_mode_ff <= !head_job.is_status && is_last;
         done_ff    <= head_job.is_status;
         status_ff  <= head_job.status;
         serr_ff    <= head_job.servo_error;
         rd_ff      <= head_job.read_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_tx_byte  = is_tx_ff;
   assign rsp_tx_byte     = tx_byte_ff;
   assign rsp_last        = last_ff;
   assign rsp_rx_mode     = rx_mode_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_status      = status_ff;
   assign rsp_servo_error = serr_ff;
   assign rsp_read_data   = rd_ff;

endmodule
`default_nettype wire

### rtl/servo_bus_packet_transactor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_bus_packet_transactor_core
// Half-duplex servo bus master: frames read/write instruction packets and
// checks the servo's status reply.
//
// req_* takes one transaction per cycle (valid/ready): read or write request,
// received bus byte, or reply timeout. A request while idle yields 8 or 9
// rsp_* results, one packet byte each; the last one turns the line to
// receive. Received bytes are buffered; the byte that completes the reply
// (or a timeout) yields one status result and the line returns to transmit.
// Requests while waiting and bytes/timeouts while idle give no result.
// The front end classifies each transaction in its accept cycle and queues a
// job; the back end emits one result per cycle from the head job unless a
// stalled rsp_ready holds it; results go via the queue and output register.
// req_ready drops only while the four-entry job queue is full, so a stalled
// rsp_ready backs up the queue before it stops the input. Reset returns the
// block to idle with an empty queue and no valid result.
// ----------------------------------------------------------------------------
module servo_bus_packet_transactor_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_servo_id,
   input  wire logic [7:0]  req_reg_addr,
   input  wire logic [15:0] req_write_data,
   input  wire logic [1:0]  req_byte_count,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_is_tx_byte,
   output      logic [7:0]  rsp_tx_byte,
   output      logic        rsp_last,
   output      logic        rsp_rx_mode,
   output      logic        rsp_done_res,
   output      logic [2:0]  rsp_status,
   output      logic [7:0]  rsp_servo_error,
   output      logic [15:0] rsp_read_data
);

   logic              accept, push, pop, full, head_valid;
   sbpt_pkg::job_type push_job, head_job;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   sbpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (req_cmd),
      .servo_id   (req_servo_id),
      .reg_addr   (req_reg_addr),
      .write_data (req_write_data),
      .byte_count (req_byte_count),
      .rx_byte    (req_rx_byte),
      .push       (push),
      .push_job   (push_job)
   );

   sbpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sbpt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_tx_byte  (rsp_is_tx_byte),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last),
      .rsp_rx_mode     (rsp_rx_mode),
      .rsp_done_res    (rsp_done_res),
      .rsp_status      (rsp_status),
      .rsp_servo_error (rsp_servo_error),
      .rsp_read_data   (rsp_read_data)
   );

endmodule
`default_nettype wire

### tb/servo_bus_packet_transactor_checker.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_transactor_checker
// Watches both channels of the servo bus transactor. Keeps its own copy of
// the master's state, works out the packet bytes and status for every
// accepted transaction, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module servo_bus_packet_transactor_checker
   import sbpt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_servo_id,
   input  wire logic [7:0]  req_reg_addr,
   input  wire logic [15:0] req_write_data,
   input  wire logic [1:0]  req_byte_count,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic        rsp_is_tx_byte,
   input  wire logic [7:0]  rsp_tx_byte,
   input  wire logic        rsp_last,
   input  wire logic        rsp_rx_mode,
   input  wire logic        rsp_done_res,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [7:0]  rsp_servo_error,
   input  wire logic [15:0] rsp_read_data,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // length field of a status packet that answers a write
   localparam logic [7:0] ACK_LEN_FIELD = 8'd2;

   typedef struct {
      logic        is_tx_byte;
      logic [7:0]  tx_byte;
      logic        last;
      logic        rx_mode;
      logic        done_res;
      logic [2:0]  status;
      logic [7:0]  servo_error;
      logic [15:0] read_data;
   } bus_result_t;

   bus_result_t awaited_results[$];

   phase_type       line_phase;
   logic            pend_write;
   logic [7:0]      pend_id;
   logic [1:0]      pend_len;
   logic [RX_COUNT_W-1:0] rx_count;
   logic [7:0]      status_buf [REPLY_BUFFER_DEPTH];

   int mismatches   = 0;
   int result_index = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at result %0d: %s got %0h expected %0h",
               result_index, what, got, want);
      mismatches++;
   endtask

   task automatic await_result(input logic is_tx, input logic [7:0] tx, input logic lst,
                               input logic rxm, input logic done, input status_type st,
                               input logic [7:0] serr, input logic [15:0] rd);
      bus_result_t r;
      r.is_tx_byte  = is_tx;
      r.tx_byte     = tx;
      r.last        = lst;
      r.rx_mode     = rxm;
      r.done_res    = done;
      r.status      = st;
      r.servo_error = serr;
      r.read_data   = rd;
      awaited_results.push_back(r);
   endtask

   // header, id, length, checksum, servo error - first failing check wins
   task automatic judge_status_packet();
      logic [7:0] len_field;
      logic [7:0] sum;
      status_type st;
      logic [7:0] serr;
      logic [15:0] rd;
      len_field = pend_write ? ACK_LEN_FIELD : {6'd0, pend_len} + ACK_LEN_FIELD;
      st   = ST_OK;
      serr = 8'd0;
      rd   = 16'd0;
      if (status_buf[0] != HEADER_BYTE || status_buf[1] != HEADER_BYTE) begin
         st = ST_HEADER;
      end else if (status_buf[2] != pend_id) begin
         st = ST_WRONG_ID;
      end else if (status_buf[3] != len_field) begin
         st = ST_BAD_LENGTH;
      end else begin
         serr = status_buf[4];
         sum  = 8'd0;
         for (int i = 2; i < len_field + 3; i++)
            sum += status_buf[i];
         if (status_buf[len_field + 3] != ~sum) begin
            st = ST_CHECKSUM;
         end else if (serr != 8'd0) begin
            st = ST_SERVO_ERROR;
         end else if (!pend_write) begin
            rd = (pend_len == 2'd2) ? {status_buf[6], status_buf[5]} : {8'd0, status_buf[5]};
         end
      end
      await_result(1'b0, 8'd0, 1'b1, 1'b0, 1'b1, st, serr, rd);
   endtask

   task automatic predict_results(input cmd_type cmd, input logic [7:0] id,
                                  input logic [7:0] addr, input logic [15:0] data,
                                  input logic [1:0] cnt, input logic [7:0] rxb);
      logic [7:0] frame [9];
      int         n;
      logic [7:0] sum;
      logic [1:0] eff;
      if (cmd == CMD_READ || cmd == CMD_WRITE) begin
         if (line_phase != PH_IDLE)
            return;
         eff = (cnt >= 2'd2) ? 2'd2 : 2'd1;
         frame[0] = HEADER_BYTE;
         frame[1] = HEADER_BYTE;
         frame[2] = id;
         frame[5] = addr;
         n = 7;
         if (cmd == CMD_READ) begin
            frame[3] = READ_LEN_FIELD;
            frame[4] = INSTR_READ;
            frame[6] = {6'd0, eff};
         end else begin
            frame[3] = {6'd0, eff} + 8'd3;
            frame[4] = INSTR_WRITE;
            frame[6] = data[7:0];
            if (eff == 2'd2) begin
               frame[7] = data[15:8];
               n = 8;
            end
         end
         sum = 8'd0;
         for (int i = 2; i < n; i++)
            sum += frame[i];
         frame[n] = ~sum;
         n++;
         for (int i = 0; i < n; i++)
            await_result(1'b1, frame[i], i == n - 1, i == n - 1, 1'b0, ST_OK, 8'd0, 16'd0);
         pend_write = (cmd == CMD_WRITE);
         pend_id    = id;
         pend_len   = eff;
         rx_count   = '0;
         line_phase = PH_RX;
      end else if (line_phase == PH_RX) begin
         if (cmd == CMD_TIMEOUT) begin
            await_result(1'b0, 8'd0, 1'b1, 1'b0, 1'b1, ST_TIMEOUT, 8'd0, 16'd0);
            line_phase = PH_IDLE;
            rx_count   = '0;
         end else begin
            if (rx_count < REPLY_BUFFER_DEPTH)
               status_buf[rx_count] = rxb;
            if (rx_count != '1)
               rx_count++;
            if (rx_count >= (pend_write ? BASE_REPLY_COUNT : BASE_REPLY_COUNT + pend_len)) begin
               judge_status_packet();
               line_phase = PH_IDLE;
               rx_count   = '0;
            end
         end
      end
   endtask

   task automatic check_result();
      bus_result_t want;
      if (awaited_results.size() == 0) begin
         report_mismatch("result with none awaited, status", rsp_status, 0);
      end else begin
         want = awaited_results.pop_front();
         if (rsp_is_tx_byte != want.is_tx_byte)
            report_mismatch("is_tx_byte", rsp_is_tx_byte, want.is_tx_byte);
         if (rsp_tx_byte != want.tx_byte)
            report_mismatch("tx_byte", rsp_tx_byte, want.tx_byte);
         if (rsp_last != want.last)
            report_mismatch("last", rsp_last, want.last);
         if (rsp_rx_mode != want.rx_mode)
            report_mismatch("rx_mode", rsp_rx_mode, want.rx_mode);
         if (rsp_done_res != want.done_res)
            report_mismatch("done_res", rsp_done_res, want.done_res);
         if (rsp_status != want.status)
            report_mismatch("status", rsp_status, want.status);
         if (rsp_servo_error != want.servo_error)
            report_mismatch("servo_error", rsp_servo_error, want.servo_error);
         if (rsp_read_data != want.read_data)
            report_mismatch("read_data", rsp_read_data, want.read_data);
      end
      result_index++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         line_phase = PH_IDLE;
         pend_write = 1'b0;
         pend_id    = 8'd0;
         pend_len   = 2'd1;
         rx_count   = '0;
         awaited_results.delete();
      end else begin
         // results of a transaction are registered and trail its acceptance
         if (rsp_valid && rsp_ready)
            check_result();
         if (req_valid && req_ready)
            predict_results(cmd_type'(req_cmd), req_servo_id, req_reg_addr, req_write_data,
                            req_byte_count, req_rx_byte);
      end
      fail_count    <= mismatches;
      pending_count <= awaited_results.size();
   end

endmodule

### tb/servo_bus_packet_transactor_core_tb.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_transactor_core_tb
// Drives read/write requests and servo status packets (clean, corrupted,
// cut short by a timeout) into the transactor, with bursty input and a
// stalling receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module servo_bus_packet_transactor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sbpt_pkg::*;

   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int ITEM_GOAL    = 280;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [7:0] ACK_LEN_FIELD = 8'd2;

   typedef enum int {
      FAULT_NONE,
      FAULT_SERVO,
      FAULT_HEADER,
      FAULT_ID,
      FAULT_LENGTH,
      FAULT_CHECKSUM,
      FAULT_TIMEOUT
   } reply_fault_t;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_MOSTLY,
      READY_LONG_STALLS
   } ready_mode_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [7:0]  req_servo_id;
   logic [7:0]  req_reg_addr;
   logic [15:0] req_write_data;
   logic [1:0]  req_byte_count;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_is_tx_byte;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last;
   logic        rsp_rx_mode;
   logic        rsp_done_res;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_servo_error;
   logic [15:0] rsp_read_data;
   int          fail_count;
   int          pending_count;

   int cycle_count = 0;
   int burst_left  = 0;
   int items_sent  = 0;
   bit sender_idle = 1'b1;

   servo_bus_packet_transactor_core i_dut (.*);

   servo_bus_packet_transactor_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // receiver: each stretch of cycles follows its own stall pattern
   initial begin
      ready_mode_t mode;
      int          stretch;
      int          stall;
      rsp_ready <= 1'b0;
      mode    = READY_ALWAYS;
      stretch = 0;
      stall   = 0;
      forever begin
         @(negedge clock);
         if (stretch == 0) begin
            mode    = ready_mode_t'($urandom_range(0, 3));
            stretch = $urandom_range(20, 150);
         end
         stretch--;
         case (mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
            default: begin
               if (stall > 0) begin
                  stall--;
                  rsp_ready <= 1'b0;
               end else if ($urandom_range(0, 9) == 0) begin
                  stall = $urandom_range(4, 20);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // called and returns at a falling edge; valid stays up within a burst
   task automatic send_item(input cmd_type cmd, input logic [7:0] id, input logic [7:0] addr,
                            input logic [15:0] data, input logic [1:0] cnt,
                            input logic [7:0] rxb);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_servo_id   <= id;
      req_reg_addr   <= addr;
      req_write_data <= data;
      req_byte_count <= cnt;
      req_rx_byte    <= rxb;
      sender_idle = 1'b0;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         sender_idle = 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic send_rx(input logic [7:0] b);
      send_item(CMD_RX_BYTE, 8'($urandom), 8'($urandom), 16'($urandom), 2'($urandom), b);
   endtask

   task automatic send_timeout();
      send_item(CMD_TIMEOUT, 8'($urandom), 8'($urandom), 16'($urandom), 2'($urandom),
                8'($urandom));
   endtask

   // hold off until every awaited result has been taken
   task automatic drain();
      if (!sender_idle)
         req_valid <= 1'b0;
      sender_idle = 1'b1;
      do
         @(negedge clock);
      while (pending_count != 0);
   endtask

   // one request followed by the servo's status packet, possibly damaged
   task automatic run_exchange(input cmd_type cmd, input logic [7:0] id,
                               input logic [7:0] addr, input logic [15:0] data,
                               input logic [1:0] cnt, input reply_fault_t fault,
                               input bit busy_request);
      logic [7:0] reply [8];
      int         n;
      int         cut;
      logic [1:0] eff;
      logic [7:0] sum;
      logic [7:0] err;
      eff = (cnt >= 2'd2) ? 2'd2 : 2'd1;
      send_item(cmd, id, addr, data, cnt, 8'($urandom));
      items_sent++;
      // a second request while waiting must be dropped
      if (busy_request)
         send_item(cmd_type'(2'($urandom_range(0, 1))), 8'($urandom), 8'($urandom),
                   16'($urandom), 2'($urandom), 8'($urandom));
      if (fault == FAULT_SERVO)
         err = 8'($urandom_range(1, 255));
      else if (fault == FAULT_NONE)
         err = 8'd0;
      else
         err = 8'($urandom);
      reply[0] = HEADER_BYTE;
      reply[1] = HEADER_BYTE;
      reply[2] = id;
      reply[3] = (cmd == CMD_WRITE) ? ACK_LEN_FIELD : {6'd0, eff} + ACK_LEN_FIELD;
      reply[4] = err;
      n = 5;
      if (cmd == CMD_READ) begin
         for (int i = 0; i < eff; i++) begin
            reply[n] = 8'($urandom);
            n++;
         end
      end
      sum = 8'd0;
      for (int i = 2; i < n; i++)
         sum += reply[i];
      reply[n] = ~sum;
      n++;
      case (fault)
         FAULT_HEADER:   reply[$urandom_range(0, 1)] = 8'($urandom_range(0, 254));
         FAULT_ID:       reply[2] ^= 8'($urandom_range(1, 255));
         FAULT_LENGTH:   reply[3] ^= 8'($urandom_range(1, 255));
         FAULT_CHECKSUM: reply[n - 1] ^= 8'($urandom_range(1, 255));
         default: ;
      endcase
      cut = (fault == FAULT_TIMEOUT) ? $urandom_range(0, n - 1) : n;
      for (int i = 0; i < cut; i++)
         send_rx(reply[i]);
      items_sent += cut;
      if (fault == FAULT_TIMEOUT) begin
         send_timeout();
         items_sent++;
      end
   endtask

   initial begin
      int           exchanges;
      int           pick;
      reply_fault_t fault;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= CMD_READ;
      req_servo_id   <= 8'd0;
      req_reg_addr   <= 8'd0;
      req_write_data <= 16'd0;
      req_byte_count <= 2'd0;
      req_rx_byte    <= 8'd0;
      exchanges = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // bytes and timeouts while idle are dropped
      send_rx(8'hFF);
      send_timeout();
      send_item(CMD_READ, 8'h00, 8'h00, 16'h0000, 2'd0, 8'h00);
      run_exchange(CMD_READ, 8'h00, 8'h00, 16'h0000, 2'd0, FAULT_NONE, 1'b1);
      run_exchange(CMD_WRITE, 8'hFF, 8'hFF, 16'hFFFF, 2'd3, FAULT_TIMEOUT, 1'b0);
      run_exchange(CMD_READ, 8'hFF, 8'h80, 16'h0000, 2'd2, FAULT_SERVO, 1'b0);
      drain();

      items_sent = 0;
      while (items_sent < ITEM_GOAL) begin
         // occasional junk, then a timeout to get back to idle
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3))
               send_item(cmd_type'(2'($urandom)), 8'($urandom), 8'($urandom),
                         16'($urandom), 2'($urandom), 8'($urandom));
            send_timeout();
         end
         pick = $urandom_range(0, 99);
         if (pick < 40)      fault = FAULT_NONE;
         else if (pick < 50) fault = FAULT_SERVO;
         else if (pick < 58) fault = FAULT_HEADER;
         else if (pick < 66) fault = FAULT_ID;
         else if (pick < 74) fault = FAULT_LENGTH;
         else if (pick < 86) fault = FAULT_CHECKSUM;
         else                fault = FAULT_TIMEOUT;
         run_exchange(cmd_type'(2'($urandom_range(0, 1))), 8'($urandom), 8'($urandom),
                      16'($urandom), 2'($urandom), fault, $urandom_range(0, 9) == 0);
         exchanges++;
         if (exchanges == 12)
            drain();
      end

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
